// File: rtl/oal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_pkg - shared types and codes of the ordered array list
// Sizes, action and status codes, and the result beat layout.
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 6;
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 3;
  localparam int ST_W     = 3;

  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [ACT_W-1:0]         act_t;
  typedef logic [ST_W-1:0]          st_t;

  localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

  localparam act_t ACT_CLEAR  = 3'd0;
  localparam act_t ACT_LOAD   = 3'd1;
  localparam act_t ACT_INSERT = 3'd2;
  localparam act_t ACT_DELETE = 3'd3;
  localparam act_t ACT_FIND   = 3'd4;
  localparam act_t ACT_DUMP   = 3'd5;

  localparam st_t ST_OK        = 3'd0;
  localparam st_t ST_FULL      = 3'd1;
  localparam st_t ST_EMPTY     = 3'd2;
  localparam st_t ST_INVALID   = 3'd3;
  localparam st_t ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    st_t  status;
    cnt_t found_position;
    val_t entry_value;
    cnt_t count;
    logic last;
  } oal_res_t;

endpackage
`default_nettype wire

// File: rtl/oal_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_if - valid/ready channels of the ordered array list
// Command channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface oal_in_if;
  import oal_pkg::*;

  logic  valid;
  logic  ready;
  act_t  action;
  val_t  value;
  cnt_t  position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface oal_out_if;
  import oal_pkg::*;

  logic  valid;
  logic  ready;
  st_t   status;
  cnt_t  found_position;
  val_t  entry_value;
  cnt_t  count;
  logic  last;

  modport source (output valid, output status, output found_position, output entry_value,
                  output count, output last, input ready);
  modport sink   (input valid, input status, input found_position, input entry_value,
                  input count, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/oal_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_ram - simple dual-port synchronous RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module oal_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/oal_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oal_ctrl - command sequencer of the ordered array list
// Decodes actions, walks the entry RAM for shifts, search and dump.
// ----------------------------------------------------------------------------
module oal_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  oal_in_if.sink                in_ch,
  input  wire logic             slot_free,
  output logic                  res_load,
  output oal_pkg::oal_res_t     res,
  output logic                  rd_en,
  output oal_pkg::addr_t        rd_addr,
  input  wire oal_pkg::val_t    rd_data,
  output logic                  wr_en,
  output oal_pkg::addr_t        wr_addr,
  output oal_pkg::val_t         wr_data
);
  import oal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT_UP, S_INS_WR, S_SHIFT_DN, S_SCAN, S_DUMP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  addr_t  idx_r, idx_nxt;
  addr_t  pos_r, pos_nxt;
  val_t   val_r, val_nxt;
  st_t    st_r, st_nxt;
  cnt_t   fpos_r, fpos_nxt;
  val_t   fval_r, fval_nxt;

  logic   in_fire;
  addr_t  in_idx;
  addr_t  last_idx;
  cnt_t   idx_pos;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_idx      = ADDR_W'(in_ch.position - CNT_W'(1));
  assign last_idx    = ADDR_W'(count_r - CNT_W'(1));
  assign idx_pos     = CNT_W'(idx_r) + CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    fpos_nxt  = fpos_r;
    fval_nxt  = fval_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data;
    res_load  = 1'b0;
    res       = '{status: st_r, found_position: fpos_r, entry_value: fval_r,
                  count: count_r, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt   = in_ch.value;
          pos_nxt   = in_idx;
          st_nxt    = ST_OK;
          fpos_nxt  = '0;
          fval_nxt  = '0;
          state_nxt = S_EMIT;
          unique case (in_ch.action) inside
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_LOAD: begin
              if (count_r >= CAP_CNT) begin
                st_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ADDR_W'(count_r);
                wr_data   = in_ch.value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_INSERT: begin
              if (count_r >= CAP_CNT) begin
                st_nxt = ST_FULL;
              end else if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else if (in_ch.position == '0 ||
                           in_ch.position > count_r + CNT_W'(1)) begin
                st_nxt = ST_INVALID;
              end else if (in_ch.position == count_r + CNT_W'(1)) begin
                // append at the tail, nothing to move
                wr_en     = 1'b1;
                wr_addr   = in_idx;
                wr_data   = in_ch.value;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = last_idx;
                idx_nxt   = last_idx;
                state_nxt = S_SHIFT_UP;
              end
            end
            ACT_DELETE: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else if (in_ch.position == '0 || in_ch.position > count_r) begin
                st_nxt = ST_INVALID;
              end else if (in_ch.position == count_r) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(in_ch.position);
                idx_nxt   = ADDR_W'(in_ch.position);
                state_nxt = S_SHIFT_DN;
              end
            end
            ACT_FIND, ACT_DUMP: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = (in_ch.action == ACT_FIND) ? S_SCAN : S_DUMP;
              end
            end
            default: begin
              // unused action codes: drop silently
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + ADDR_W'(1);
        if (idx_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r - ADDR_W'(1);
          idx_nxt = idx_r - ADDR_W'(1);
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_EMIT;
      end
      S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - ADDR_W'(1);
        if (idx_r == last_idx) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_SCAN: begin
        if (rd_data == val_r) begin
          fpos_nxt  = idx_pos;
          fval_nxt  = rd_data;
          state_nxt = S_EMIT;
        end else if (idx_r == last_idx) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          res_load = 1'b1;
          res      = '{status: ST_OK, found_position: idx_pos, entry_value: rd_data,
                       count: count_r, last: (idx_r == last_idx)};
          if (idx_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + ADDR_W'(1);
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    st_r   <= st_nxt;
    fpos_r <= fpos_nxt;
    fval_r <= fval_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> slot_free)
    else $error("result loaded into an occupied output slot");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry in one cycle");

  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_addr) < count_r))
    else $error("read of an entry beyond the list");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.action == ACT_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the list");

endmodule
`default_nettype wire

// File: rtl/ordered_array_list_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_list_core - bounded ordered list of signed 32-bit words
// Command sequencer around one entry RAM, with a registered result slot.
// ----------------------------------------------------------------------------
// Sequencing: clear, load, error cases, tail insert and tail delete pass
//   through S_EMIT and then the registered output slot; insert walks
//   S_SHIFT_UP then S_INS_WR, delete walks S_SHIFT_DN, find walks S_SCAN.
// Throughput: one command at a time; the walks move one entry per cycle,
//   bounded by the single read and single write port of the entry RAM.
//   Dump streams one beat per cycle while out is ready.
// Reset: clears the entry count, sequencer state and output valid; the
//   entry RAM is not cleared since only live positions are ever read.
// ----------------------------------------------------------------------------
module ordered_array_list_core (
  input  wire logic clk,
  input  wire logic rst_n,
  oal_in_if.sink    in_ch,
  oal_out_if.source out_ch
);
  import oal_pkg::*;

  // RAM port nets between the sequencer and the entry store
  logic     rd_en;
  addr_t    rd_addr;
  val_t     rd_data;
  logic     wr_en;
  addr_t    wr_addr;
  val_t     wr_data;

  // Result hand-off from the sequencer
  logic     res_load;
  oal_res_t res;
  logic     slot_free;

  // Output slot: one registered beat, refilled in the cycle it drains
  logic     out_valid_r, out_valid_nxt;
  oal_res_t out_res_r, out_res_nxt;

  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  oal_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The slot can take a new beat when empty or when its beat leaves now
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      // advance: a fresh beat replaces the one leaving
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      // drop the beat once taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.found_position = out_res_r.found_position;
  assign out_ch.entry_value    = out_res_r.entry_value;
  assign out_ch.count          = out_res_r.count;
  assign out_ch.last           = out_res_r.last;

endmodule
`default_nettype wire
